// ===== design/fpq_pkg.sv =====
// ----------------------------------------------------------------------------
// fpq_pkg: shared types and constants for the frame pool ready queue
// Pool and queue sizes, operation and frame state codes, and the command and
// status words passed between the control logic and its two storage blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package fpq_pkg;

  // Pool and queue sizes
  localparam int FRAME_COUNT = 8;
  localparam int QUEUE_DEPTH = 8;

  // Fixed port widths
  localparam int OP_W        = 3;
  localparam int ID_W        = 8;
  localparam int OUT_FRAME_W = 3;
  localparam int COUNT_W     = 4;

  // Derived internal widths
  localparam int FRAME_IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int FCNT_W      = $clog2(FRAME_COUNT + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd0;
  localparam logic [OP_W-1:0] OP_ACQUIRE    = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK_READY = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_READY  = 3'd3;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd4;
  localparam logic [OP_W-1:0] OP_TX_BUSY    = 3'd5;
  localparam logic [OP_W-1:0] OP_FREE       = 3'd6;

  // Frame states
  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_FILLING = 2'd1;
  localparam logic [1:0] ST_READY   = 2'd2;
  localparam logic [1:0] ST_TXBUSY  = 2'd3;

  typedef logic [FRAME_IDX_W-1:0] frame_idx_t;

  typedef struct packed {
    logic       clr;
    logic       wr;
    frame_idx_t idx;
    logic [1:0] val;
  } pool_cmd_t;

  typedef struct packed {
    logic       any_free;
    frame_idx_t low_free;
  } pool_sts_t;

  typedef struct packed {
    logic       clr;
    logic       push_back;
    logic       push_front;
    logic       pop;
    frame_idx_t id;
  } queue_cmd_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    frame_idx_t head_slot;
  } queue_sts_t;

endpackage

`default_nettype wire

// ===== design/frame_pool_ready_queue.sv =====
// ----------------------------------------------------------------------------
// frame_pool_ready_queue: frame buffer pool manager with ready queue
// Tracks the state of each frame by index and keeps a queue of ready frames;
// one operation per word, one result word per operation.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                    | handshake
//  ----------+------------------------------------------+---------------------
//  input     | in_op, in_frame_id                       | start && !busy
//  result    | out_ok, out_frame_out, out_ready_count,  | out_valid, one cycle,
//            | out_free_count                           | cannot be held off
//
//  A word is taken in every cycle; busy is held low since nothing stalls.
//  A word goes through the input register, then the decode and state
//  update with the result register. The state update of one word is seen by
//  the very next word, so back-to-back words need no bypass.
//  Synchronous reset frees every frame and empties the queue; queue slot
//  contents are not reset and are only read while inside the queue.
//
`default_nettype none

module frame_pool_ready_queue (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [fpq_pkg::OP_W-1:0]        in_op,
  input  wire logic [fpq_pkg::ID_W-1:0]        in_frame_id,
  output logic                                 out_valid,
  output logic                                 out_ok,
  output logic [fpq_pkg::OUT_FRAME_W-1:0]      out_frame_out,
  output logic [fpq_pkg::COUNT_W-1:0]          out_ready_count,
  output logic [fpq_pkg::COUNT_W-1:0]          out_free_count
);

  // Input register
  logic                          in_vld_r;
  logic [fpq_pkg::OP_W-1:0]      op_r;
  logic [fpq_pkg::ID_W-1:0]      id_r;

  // Result register
  logic                          out_valid_r;
  logic                          ok_r;
  fpq_pkg::frame_idx_t           fout_r;
  logic [fpq_pkg::COUNT_W-1:0]   ready_cnt_r;
  logic [fpq_pkg::COUNT_W-1:0]   free_cnt_r;

  // Decode outputs
  logic                          ok_nxt;
  fpq_pkg::frame_idx_t           fout_nxt;
  logic                          id_ok;
  fpq_pkg::frame_idx_t           id_idx;

  fpq_pkg::pool_cmd_t            pool_cmd;
  fpq_pkg::pool_sts_t            pool_sts;
  fpq_pkg::queue_cmd_t           q_cmd;
  fpq_pkg::queue_sts_t           q_sts;
  logic [fpq_pkg::FCNT_W-1:0]    free_cnt_nxt;
  logic [fpq_pkg::QCNT_W-1:0]    q_cnt_nxt;

  assign busy = 1'b0;

  // Capture every accepted word; the payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r <= in_op;
      id_r <= in_frame_id;
    end
  end

  assign id_ok  = (id_r < fpq_pkg::ID_W'(fpq_pkg::FRAME_COUNT));
  assign id_idx = id_r[fpq_pkg::FRAME_IDX_W-1:0];

  // Decode the held word into pool and queue commands. Rejected words
  // (bad id, queue full or empty, no free frame, unused code) drop to ok low
  // and leave all state alone.
  always_comb begin
    ok_nxt   = 1'b0;
    fout_nxt = '0;
    pool_cmd = '0;
    q_cmd    = '0;
    q_cmd.id = id_idx;
    if (in_vld_r) begin
      case (op_r)
        fpq_pkg::OP_CLEAR: begin
          ok_nxt       = 1'b1;
          pool_cmd.clr = 1'b1;
          q_cmd.clr    = 1'b1;
        end
        fpq_pkg::OP_ACQUIRE: begin
          if (pool_sts.any_free) begin
            ok_nxt       = 1'b1;
            fout_nxt     = pool_sts.low_free;
            pool_cmd.wr  = 1'b1;
            pool_cmd.idx = pool_sts.low_free;
            pool_cmd.val = fpq_pkg::ST_FILLING;
          end
        end
        fpq_pkg::OP_MARK_READY: begin
          if (id_ok && !q_sts.full) begin
            ok_nxt          = 1'b1;
            q_cmd.push_back = 1'b1;
            pool_cmd.wr     = 1'b1;
            pool_cmd.idx    = id_idx;
            pool_cmd.val    = fpq_pkg::ST_READY;
          end
        end
        fpq_pkg::OP_POP_READY: begin
          if (!q_sts.empty) begin
            ok_nxt    = 1'b1;
            fout_nxt  = q_sts.head_slot;
            q_cmd.pop = 1'b1;
          end
        end
        fpq_pkg::OP_PUSH_FRONT: begin
          if (id_ok && !q_sts.full) begin
            ok_nxt           = 1'b1;
            q_cmd.push_front = 1'b1;
            pool_cmd.wr      = 1'b1;
            pool_cmd.idx     = id_idx;
            pool_cmd.val     = fpq_pkg::ST_READY;
          end
        end
        fpq_pkg::OP_TX_BUSY: begin
          if (id_ok) begin
            ok_nxt       = 1'b1;
            pool_cmd.wr  = 1'b1;
            pool_cmd.idx = id_idx;
            pool_cmd.val = fpq_pkg::ST_TXBUSY;
          end
        end
        fpq_pkg::OP_FREE: begin
          if (id_ok) begin
            ok_nxt       = 1'b1;
            pool_cmd.wr  = 1'b1;
            pool_cmd.idx = id_idx;
            pool_cmd.val = fpq_pkg::ST_FREE;
          end
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  fpq_frame_pool u_pool (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (pool_cmd),
    .sts            (pool_sts),
    .free_count_nxt (free_cnt_nxt)
  );

  fpq_ready_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .sts       (q_sts),
    .count_nxt (q_cnt_nxt)
  );

  // Result register: counts reflect the state after this word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      ok_r        <= ok_nxt;
      fout_r      <= fout_nxt;
      ready_cnt_r <= fpq_pkg::COUNT_W'(q_cnt_nxt);
      free_cnt_r  <= fpq_pkg::COUNT_W'(free_cnt_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_frame_out   = fpq_pkg::OUT_FRAME_W'(fout_r);
  assign out_ready_count = ready_cnt_r;
  assign out_free_count  = free_cnt_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted word did not produce a result two cycles later");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_frame_out == '0))
    else $error("frame_out not zero on a rejected word");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && (op_r == fpq_pkg::OP_CLEAR)) |=>
      (out_ok && (out_ready_count == '0)
       && (out_free_count == fpq_pkg::COUNT_W'(fpq_pkg::FRAME_COUNT))))
    else $error("clear did not empty the queue and free every frame");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && (op_r == fpq_pkg::OP_POP_READY) && q_sts.empty) |=>
      (!out_ok && (out_ready_count == '0)))
    else $error("pop on an empty queue was not flagged");
`endif

endmodule

`default_nettype wire

// ===== design/fpq_frame_pool.sv =====
// ----------------------------------------------------------------------------
// fpq_frame_pool: per-frame state table
// Holds the state of every frame, finds the lowest free frame and counts the
// free frames after the pending update.
// ----------------------------------------------------------------------------
`default_nettype none

module fpq_frame_pool (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fpq_pkg::pool_cmd_t          cmd,
  output fpq_pkg::pool_sts_t               sts,
  output logic [fpq_pkg::FCNT_W-1:0]       free_count_nxt
);

  logic [1:0] status_r   [fpq_pkg::FRAME_COUNT];
  logic [1:0] status_nxt [fpq_pkg::FRAME_COUNT];

  // Apply clear or a single-entry write
  always_comb begin
    for (int i = 0; i < fpq_pkg::FRAME_COUNT; i++) begin
      if (cmd.clr) begin
        status_nxt[i] = fpq_pkg::ST_FREE;
      end else if (cmd.wr && (int'(cmd.idx) == i)) begin
        status_nxt[i] = cmd.val;
      end else begin
        status_nxt[i] = status_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < fpq_pkg::FRAME_COUNT; i++) begin
      if (!rst_n) begin
        status_r[i] <= fpq_pkg::ST_FREE;
      end else begin
        status_r[i] <= status_nxt[i];
      end
    end
  end

  // Lowest-numbered free frame: scan from the top so the lowest wins
  always_comb begin
    sts.any_free = 1'b0;
    sts.low_free = '0;
    for (int i = fpq_pkg::FRAME_COUNT - 1; i >= 0; i--) begin
      if (status_r[i] == fpq_pkg::ST_FREE) begin
        sts.any_free = 1'b1;
        sts.low_free = fpq_pkg::FRAME_IDX_W'(i);
      end
    end
  end

  always_comb begin
    free_count_nxt = '0;
    for (int i = 0; i < fpq_pkg::FRAME_COUNT; i++) begin
      if (status_nxt[i] == fpq_pkg::ST_FREE) begin
        free_count_nxt = free_count_nxt + fpq_pkg::FCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/fpq_ready_ring.sv =====
// ----------------------------------------------------------------------------
// fpq_ready_ring: ready queue of frame indices
// Circular buffer with append at the tail, retry at the head and pop from
// the head. Slot contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fpq_ready_ring (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fpq_pkg::queue_cmd_t         cmd,
  output fpq_pkg::queue_sts_t              sts,
  output logic [fpq_pkg::QCNT_W-1:0]       count_nxt
);

  localparam logic [fpq_pkg::QPTR_W-1:0] LAST_PTR = fpq_pkg::QPTR_W'(fpq_pkg::QUEUE_DEPTH - 1);

  fpq_pkg::frame_idx_t          slots_r [fpq_pkg::QUEUE_DEPTH];
  logic [fpq_pkg::QPTR_W-1:0]   head_r, head_nxt;
  logic [fpq_pkg::QPTR_W-1:0]   tail_r, tail_nxt;
  logic [fpq_pkg::QCNT_W-1:0]   count_r;
  logic [fpq_pkg::QPTR_W-1:0]   head_inc, head_dec, tail_inc;

  assign head_inc = (head_r == LAST_PTR) ? '0 : head_r + fpq_pkg::QPTR_W'(1);
  assign head_dec = (head_r == '0) ? LAST_PTR : head_r - fpq_pkg::QPTR_W'(1);
  assign tail_inc = (tail_r == LAST_PTR) ? '0 : tail_r + fpq_pkg::QPTR_W'(1);

  assign sts.full      = (count_r == fpq_pkg::QCNT_W'(fpq_pkg::QUEUE_DEPTH));
  assign sts.empty     = (count_r == '0);
  assign sts.head_slot = slots_r[head_r];

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.clr) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.push_back) begin
      tail_nxt  = tail_inc;
      count_nxt = count_r + fpq_pkg::QCNT_W'(1);
    end else if (cmd.push_front) begin
      head_nxt  = head_dec;
      count_nxt = count_r + fpq_pkg::QCNT_W'(1);
    end else if (cmd.pop) begin
      head_nxt  = head_inc;
      count_nxt = count_r - fpq_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Single slot write per cycle: at the tail, or just ahead of the head
  always_ff @(posedge clk) begin
    if (cmd.push_back) begin
      slots_r[tail_r] <= cmd.id;
    end else if (cmd.push_front) begin
      slots_r[head_dec] <= cmd.id;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_frame_pool_ready_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_pool_ready_queue: self-checking bench for the frame pool manager
// Drives operation words into the block and predicts every result word from a
// behavioral copy of the frame states and the ready queue. A short directed
// list hits every operation, bad ids, underflow and exhaustion, then random
// bursts fill and drain the pool under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_frame_pool_ready_queue;

  // No package constant covers the one spare op code.
  localparam logic [fpq_pkg::OP_W-1:0] OP_UNUSED      = 3'd7;
  localparam int                       WATCHDOG_LIMIT = 2000;
  localparam int                       DRAIN_CYCLES   = 8;
  localparam int                       RANDOM_WORDS   = 1700;

  // One operation word as queued for the driver, with its sender idle rate.
  typedef struct {
    logic [fpq_pkg::OP_W-1:0] op;
    logic [fpq_pkg::ID_W-1:0] frame_id;
    int unsigned              idle_pct;
  } pool_word_t;

  // One result word as seen on the out_ ports.
  typedef struct packed {
    logic                            ok;
    logic [fpq_pkg::OUT_FRAME_W-1:0] frame;
    logic [fpq_pkg::COUNT_W-1:0]     ready_count;
    logic [fpq_pkg::COUNT_W-1:0]     free_count;
  } pool_status_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic [fpq_pkg::OP_W-1:0]        in_op = '0;
  logic [fpq_pkg::ID_W-1:0]        in_frame_id = '0;
  logic                            busy;
  logic                            out_valid;
  logic                            out_ok;
  logic [fpq_pkg::OUT_FRAME_W-1:0] out_frame_out;
  logic [fpq_pkg::COUNT_W-1:0]     out_ready_count;
  logic [fpq_pkg::COUNT_W-1:0]     out_free_count;

  pool_word_t   pending_words[$];
  pool_status_t expected_status[$];
  logic         word_taken = 1'b0;
  int           fail_count = 0;
  int           idle_cycles = 0;

  // Behavioral copy of the pool: frame states, queue slots, head, tail, count.
  logic [1:0]                      frame_state[fpq_pkg::FRAME_COUNT];
  logic [fpq_pkg::OUT_FRAME_W-1:0] ready_slot[fpq_pkg::QUEUE_DEPTH];
  int                              q_head;
  int                              q_tail;
  int                              q_count;

  frame_pool_ready_queue u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_frame_id     (in_frame_id),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_frame_out   (out_frame_out),
    .out_ready_count (out_ready_count),
    .out_free_count  (out_free_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Apply one operation to the pool copy and return the status it reports.
  function automatic pool_status_t apply_pool_op(input logic [fpq_pkg::OP_W-1:0] op,
                                                 input logic [fpq_pkg::ID_W-1:0] id);
    pool_status_t r;
    logic         id_ok;
    int           free_n;
    r = '0;
    id_ok = (id < fpq_pkg::FRAME_COUNT);
    case (op)
      fpq_pkg::OP_CLEAR: begin
        // Free everything and empty the queue; slot contents stay.
        for (int i = 0; i < fpq_pkg::FRAME_COUNT; i++) frame_state[i] = fpq_pkg::ST_FREE;
        q_head = 0;
        q_tail = 0;
        q_count = 0;
        r.ok = 1'b1;
      end
      fpq_pkg::OP_ACQUIRE: begin
        // Take the lowest-numbered free frame, if any.
        for (int i = 0; i < fpq_pkg::FRAME_COUNT; i++) begin
          if (!r.ok && frame_state[i] == fpq_pkg::ST_FREE) begin
            frame_state[i] = fpq_pkg::ST_FILLING;
            r.frame = i[fpq_pkg::OUT_FRAME_W-1:0];
            r.ok = 1'b1;
          end
        end
      end
      fpq_pkg::OP_MARK_READY: begin
        if (id_ok && q_count < fpq_pkg::QUEUE_DEPTH) begin
          ready_slot[q_tail] = id[fpq_pkg::OUT_FRAME_W-1:0];
          q_tail = (q_tail + 1) % fpq_pkg::QUEUE_DEPTH;
          q_count++;
          frame_state[id] = fpq_pkg::ST_READY;
          r.ok = 1'b1;
        end
      end
      fpq_pkg::OP_POP_READY: begin
        // A popped frame keeps its state.
        if (q_count != 0) begin
          r.frame = ready_slot[q_head];
          q_head = (q_head + 1) % fpq_pkg::QUEUE_DEPTH;
          q_count--;
          r.ok = 1'b1;
        end
      end
      fpq_pkg::OP_PUSH_FRONT: begin
        if (id_ok && q_count < fpq_pkg::QUEUE_DEPTH) begin
          q_head = (q_head + fpq_pkg::QUEUE_DEPTH - 1) % fpq_pkg::QUEUE_DEPTH;
          ready_slot[q_head] = id[fpq_pkg::OUT_FRAME_W-1:0];
          q_count++;
          frame_state[id] = fpq_pkg::ST_READY;
          r.ok = 1'b1;
        end
      end
      fpq_pkg::OP_TX_BUSY: begin
        if (id_ok) begin
          frame_state[id] = fpq_pkg::ST_TXBUSY;
          r.ok = 1'b1;
        end
      end
      fpq_pkg::OP_FREE: begin
        if (id_ok) begin
          frame_state[id] = fpq_pkg::ST_FREE;
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    free_n = 0;
    for (int i = 0; i < fpq_pkg::FRAME_COUNT; i++) begin
      if (frame_state[i] == fpq_pkg::ST_FREE) free_n++;
    end
    r.ready_count = q_count[fpq_pkg::COUNT_W-1:0];
    r.free_count  = free_n[fpq_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic queue_word(input logic [fpq_pkg::OP_W-1:0] op, input int id,
                            input int unsigned idle);
    pool_word_t w;
    w.op       = op;
    w.frame_id = id[fpq_pkg::ID_W-1:0];
    w.idle_pct = idle;
    pending_words.push_back(w);
  endtask

  // Queue random bursts: each burst leans toward filling the pool and queue,
  // draining them, or a plain mix, so full and empty states come up often.
  task automatic queue_random_words(input int count, input int unsigned idle);
    int                       left;
    int                       burst_len;
    int                       lean;
    int                       roll;
    logic [fpq_pkg::OP_W-1:0] op;
    int                       id;
    left = count;
    while (left > 0) begin
      lean = $urandom_range(2);
      burst_len = $urandom_range(24, 4);
      for (int n = 0; n < burst_len && left > 0; n++) begin
        roll = $urandom_range(99);
        if (lean == 0) begin
          if (roll < 30)      op = fpq_pkg::OP_ACQUIRE;
          else if (roll < 60) op = fpq_pkg::OP_MARK_READY;
          else if (roll < 80) op = fpq_pkg::OP_PUSH_FRONT;
          else if (roll < 88) op = fpq_pkg::OP_TX_BUSY;
          else if (roll < 94) op = fpq_pkg::OP_POP_READY;
          else                op = fpq_pkg::OP_FREE;
        end else if (lean == 1) begin
          if (roll < 35)      op = fpq_pkg::OP_POP_READY;
          else if (roll < 60) op = fpq_pkg::OP_FREE;
          else if (roll < 75) op = fpq_pkg::OP_TX_BUSY;
          else if (roll < 85) op = fpq_pkg::OP_ACQUIRE;
          else if (roll < 93) op = fpq_pkg::OP_MARK_READY;
          else                op = fpq_pkg::OP_PUSH_FRONT;
        end else begin
          op = fpq_pkg::OP_W'($urandom_range(fpq_pkg::OP_FREE));
        end
        // Sprinkle in rare clears and the spare code.
        roll = $urandom_range(99);
        if (roll < 2)       op = fpq_pkg::OP_CLEAR;
        else if (roll == 2) op = OP_UNUSED;
        // Mostly valid ids; the rest span the whole id field.
        if ($urandom_range(99) < 90) id = $urandom_range(fpq_pkg::FRAME_COUNT - 1);
        else                         id = $urandom_range(255);
        queue_word(op, id, idle);
        left--;
      end
    end
  endtask

  // Driver: present a word at the falling edge, hold it until taken.
  always @(negedge clk) begin : drive_words
    pool_word_t w;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (pending_words.size() != 0 &&
          $urandom_range(99) >= pending_words[0].idle_pct) begin
        w = pending_words.pop_front();
        start       <= 1'b1;
        in_op       <= w.op;
        in_frame_id <= w.frame_id;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check result words, then predict for the word taken this edge.
  always @(posedge clk) begin : check_words
    pool_status_t want;
    if (!rst_n) begin
      // Hold the pool copy in its reset state.
      for (int i = 0; i < fpq_pkg::FRAME_COUNT; i++) frame_state[i] = fpq_pkg::ST_FREE;
      for (int i = 0; i < fpq_pkg::QUEUE_DEPTH; i++) ready_slot[i] = '0;
      q_head = 0;
      q_tail = 0;
      q_count = 0;
      word_taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (expected_status.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          want = expected_status.pop_front();
          if (out_ok !== want.ok) begin
            $error("out_ok: expected %0d, got %0d", want.ok, out_ok);
            fail_count++;
          end
          if (out_frame_out !== want.frame) begin
            $error("out_frame_out: expected %0d, got %0d", want.frame, out_frame_out);
            fail_count++;
          end
          if (out_ready_count !== want.ready_count) begin
            $error("out_ready_count: expected %0d, got %0d",
                   want.ready_count, out_ready_count);
            fail_count++;
          end
          if (out_free_count !== want.free_count) begin
            $error("out_free_count: expected %0d, got %0d",
                   want.free_count, out_free_count);
            fail_count++;
          end
        end
      end
      word_taken <= start && !busy;
      if (start && !busy) expected_status.push_back(apply_pool_op(in_op, in_frame_id));
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb_frame_pool_ready_queue failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // Directed words: spare code, underflow, exhaustion, bad ids at both
    // extremes, every operation, a frame queued twice, and clear.
    queue_word(OP_UNUSED, 255, 0);
    queue_word(fpq_pkg::OP_POP_READY, 0, 0);
    for (int i = 0; i <= fpq_pkg::FRAME_COUNT; i++) queue_word(fpq_pkg::OP_ACQUIRE, 0, 0);
    queue_word(fpq_pkg::OP_MARK_READY, 255, 0);
    queue_word(fpq_pkg::OP_MARK_READY, fpq_pkg::FRAME_COUNT, 0);
    queue_word(fpq_pkg::OP_MARK_READY, 7, 0);
    queue_word(fpq_pkg::OP_PUSH_FRONT, 0, 0);
    queue_word(fpq_pkg::OP_MARK_READY, 3, 0);
    queue_word(fpq_pkg::OP_MARK_READY, 3, 0);
    queue_word(fpq_pkg::OP_POP_READY, 0, 0);
    queue_word(fpq_pkg::OP_TX_BUSY, 7, 0);
    queue_word(fpq_pkg::OP_TX_BUSY, fpq_pkg::FRAME_COUNT, 0);
    queue_word(fpq_pkg::OP_FREE, 255, 0);
    queue_word(fpq_pkg::OP_FREE, 0, 0);
    queue_word(fpq_pkg::OP_PUSH_FRONT, 200, 0);
    queue_word(fpq_pkg::OP_CLEAR, 170, 0);
    queue_word(fpq_pkg::OP_ACQUIRE, 85, 0);

    // Random phases: no idling, sender idle 83 of 100, a receiver-stall
    // phase (nothing to stall, so the sender runs flat out), then sender idle 38.
    queue_random_words(RANDOM_WORDS / 4, 0);
    queue_random_words(RANDOM_WORDS / 4, 83);
    queue_random_words(RANDOM_WORDS / 4, 0);
    queue_random_words(RANDOM_WORDS / 4, 38);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the driver to run dry, then for every result word.
    while (pending_words.size() != 0 || start) @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_frame_pool_ready_queue passed");
    end else begin
      $display("tb_frame_pool_ready_queue failed");
    end
    $finish;
  end

endmodule
